[hw/rtl/h2r_pkg.sv]
// types and constants shared by the hsv to rgb converter and its checker
`timescale 1ns / 1ps

package h2r_pkg;

  localparam int HUE_W   = 13;
  localparam int PIX_W   = 8;
  localparam int REM_W   = 10;
  localparam int QUOT_W  = 4;
  localparam int NUM_W   = 18;
  localparam int PROD_W  = NUM_W + PIX_W;
  localparam int RECIP_W = 9;
  localparam int EST_W   = PROD_W + RECIP_W;

  localparam logic [REM_W-1:0]   SECTOR_SPAN  = REM_W'(960);
  localparam int                 SECTOR_COUNT = 6;
  localparam int                 MAX_QUOT     = ((1 << HUE_W) - 1) / 960;
  localparam logic [NUM_W-1:0]   FULL_NUM     = NUM_W'(255 * 960);
  localparam int                 RECIP_SHIFT  = PROD_W;
  localparam logic [RECIP_W-1:0] RECIP        = RECIP_W'((1 << PROD_W) / (255 * 960));

  localparam int NUM_LANES = 3;
  localparam int LANE_P    = 0;
  localparam int LANE_Q    = 1;
  localparam int LANE_T    = 2;

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

endpackage

[hw/rtl/hsv_to_rgb_converter.sv]
// five stage pipelined hsv to rgb color converter
// an accepted beat passes from the stage 1 registers through stages 2, 3 and 4 into the rgb register
// throughput: one beat per cycle while rgb is not stalled, set by the five register stages
// each stage holds its beat only when every stage ahead of it is full and rgb is stalled
// reset clears the stage valid bits; no beat is in flight afterwards
`timescale 1ns / 1ps

module hsv_to_rgb_converter (
  input  logic          clk,
  input  logic          rst,
  input  logic          hsv_valid,
  output logic          hsv_stall,
  input  h2r_pkg::hsv_t hsv,
  output logic          rgb_valid,
  input  logic          rgb_stall,
  output h2r_pkg::rgb_t rgb
);
  import h2r_pkg::*;

  logic en1, en2, en3, en4, en5;
  logic s1_valid, s2_valid, s3_valid, s4_valid;

  // stage 1 registers
  sector_t          s1_sector;
  logic [REM_W-1:0] s1_rem;
  logic [PIX_W-1:0] s1_sat;
  logic [PIX_W-1:0] s1_val;

  // stage 2 registers
  sector_t          s2_sector;
  logic [PIX_W-1:0] s2_val;
  logic [NUM_W-1:0] s2_num [NUM_LANES];

  // stage 3 registers
  sector_t           s3_sector;
  logic [PIX_W-1:0]  s3_val;
  logic [PROD_W-1:0] s3_prod [NUM_LANES];

  // stage 4 registers
  sector_t           s4_sector;
  logic [PIX_W-1:0]  s4_val;
  logic [PROD_W-1:0] s4_prod [NUM_LANES];
  logic [PIX_W-1:0]  s4_est  [NUM_LANES];

  logic [QUOT_W-1:0] quot;
  logic [REM_W-1:0]  rem;
  sector_t           sector;
  logic [NUM_W-1:0]  num  [NUM_LANES];
  logic [EST_W-1:0]  prod_scaled [NUM_LANES];
  logic [PROD_W-1:0] rmd  [NUM_LANES];
  logic [PIX_W-1:0]  lvl  [NUM_LANES];
  rgb_t              rgb_next;

  // stage enables, a stage moves when empty or when the next one moves
  assign en5       = !rgb_valid || !rgb_stall;
  assign en4       = !s4_valid || en5;
  assign en3       = !s3_valid || en4;
  assign en2       = !s2_valid || en3;
  assign en1       = !s1_valid || en2;
  assign hsv_stall = !en1;

  // sector split by parallel compares against multiples of the span
  always_comb begin
    quot = '0;
    for (int k = 1; k <= MAX_QUOT; k++) begin
      if (hsv.hue >= HUE_W'(k * 960)) begin
        quot = QUOT_W'(k);
      end
    end
    rem = REM_W'(hsv.hue - HUE_W'(HUE_W'(quot) * HUE_W'(SECTOR_SPAN)));
    if (quot >= QUOT_W'(SECTOR_COUNT)) begin
      sector = sector_t'(3'(quot - QUOT_W'(SECTOR_COUNT)));
    end else begin
      sector = sector_t'(3'(quot));
    end
  end

  // numerators over the common denominator 255*960
  always_comb begin
    num[LANE_P] = NUM_W'(NUM_W'(PIX_W'(~s1_sat)) * NUM_W'(SECTOR_SPAN));
    num[LANE_Q] = FULL_NUM - NUM_W'(NUM_W'(s1_sat) * NUM_W'(s1_rem));
    num[LANE_T] = FULL_NUM - NUM_W'(NUM_W'(s1_sat) * NUM_W'(SECTOR_SPAN - s1_rem));
  end

  // reciprocal estimate, low by at most one
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      prod_scaled[i] = EST_W'(s3_prod[i]) * EST_W'(RECIP);
    end
  end

  // remainder check fixes the estimate
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      rmd[i] = s4_prod[i] - PROD_W'(PROD_W'(s4_est[i]) * PROD_W'(FULL_NUM));
      lvl[i] = s4_est[i] + PIX_W'(rmd[i] >= PROD_W'(FULL_NUM));
    end
  end

  always_comb begin
    unique case (s4_sector)
      SECTOR_0: begin
        rgb_next = '{red: s4_val, green: lvl[LANE_T], blue: lvl[LANE_P]};
      end
      SECTOR_1: begin
        rgb_next = '{red: lvl[LANE_Q], green: s4_val, blue: lvl[LANE_P]};
      end
      SECTOR_2: begin
        rgb_next = '{red: lvl[LANE_P], green: s4_val, blue: lvl[LANE_T]};
      end
      SECTOR_3: begin
        rgb_next = '{red: lvl[LANE_P], green: lvl[LANE_Q], blue: s4_val};
      end
      SECTOR_4: begin
        rgb_next = '{red: lvl[LANE_T], green: lvl[LANE_P], blue: s4_val};
      end
      default: begin
        rgb_next = '{red: s4_val, green: lvl[LANE_P], blue: lvl[LANE_Q]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= hsv_valid;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (en3) begin
        s3_valid <= s2_valid;
      end
      if (en4) begin
        s4_valid <= s3_valid;
      end
      if (en5) begin
        rgb_valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sector <= sector;
      s1_rem    <= rem;
      s1_sat    <= hsv.saturation;
      s1_val    <= hsv.brightness;
    end
    if (en2) begin
      s2_sector <= s1_sector;
      s2_val    <= s1_val;
      for (int i = 0; i < NUM_LANES; i++) begin
        s2_num[i] <= num[i];
      end
    end
    if (en3) begin
      s3_sector <= s2_sector;
      s3_val    <= s2_val;
      for (int i = 0; i < NUM_LANES; i++) begin
        s3_prod[i] <= PROD_W'(s2_val) * PROD_W'(s2_num[i]);
      end
    end
    if (en4) begin
      s4_sector <= s3_sector;
      s4_val    <= s3_val;
      for (int i = 0; i < NUM_LANES; i++) begin
        s4_prod[i] <= s3_prod[i];
        s4_est[i]  <= prod_scaled[i][RECIP_SHIFT +: PIX_W];
      end
    end
    if (en5) begin
      rgb <= rgb_next;
    end
  end

endmodule

[hw/rtl/h2r_checker.sv]
// port level checker for the hsv to rgb converter and its bind
`timescale 1ns / 1ps

module h2r_checker (
  input logic          clk,
  input logic          rst,
  input logic          hsv_valid,
  input logic          hsv_stall,
  input h2r_pkg::hsv_t hsv,
  input logic          rgb_valid,
  input logic          rgb_stall,
  input h2r_pkg::rgb_t rgb
);
  import h2r_pkg::*;

  // reset empties the pipeline
  a_reset_empty : assert property (@(posedge clk) rst |=> !rgb_valid)
    else $error("rgb beat valid right after reset");

  // input only stalls when rgb holds a valid beat and is stalled
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    hsv_stall |-> (rgb_valid && rgb_stall))
    else $error("hsv stalled while the pipeline could advance");

  // a stalled rgb beat stays put
  a_rgb_hold : assert property (@(posedge clk) disable iff (rst)
    (rgb_valid && rgb_stall) |=> (rgb_valid && $stable(rgb)))
    else $error("stalled rgb beat changed");

  // an accepted beat with rgb never stalled on its way through the stages shows on rgb
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && !hsv_stall) ##1 (!rgb_stall [*4]) |=> rgb_valid)
    else $error("accepted beat did not reach rgb in four cycles");

endmodule

bind hsv_to_rgb_converter h2r_checker u_h2r_checker (.*);
